/* hw/rtl/isp_pkg.sv */
// Package for the interpolating sample player: widths, operation and register codes,
// reset values and the tag types that travel with memory reads. It has no dependencies.
package isp_pkg;

  localparam int FRAC_W     = 16;               // fraction bits of the read position
  localparam int ADDR_W     = 16;               // sample memory address width
  localparam int SAMPLE_W   = 16;               // sample word width
  localparam int COUNT_W    = 17;               // sample_count register width
  localparam int INC_W      = 24;               // phase_increment register width
  localparam int POS_W      = COUNT_W + FRAC_W; // read position width
  localparam int CFG_W      = 24;               // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int OP_W       = 2;
  localparam int VAL_W      = SAMPLE_W + FRAC_W + 2; // one channel scaled by 2^FRAC_W
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int PEND_W     = 3;                // holds 0 .. FIFO_DEPTH
  localparam int LEFT_W     = 2;                // reads still to issue for a tick

  localparam logic [INC_W-1:0]   INC_RESET   = INC_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(65536);

  // Reads that follow the first one of a tick.
  localparam logic [LEFT_W-1:0] MONO_MORE_READS   = LEFT_W'(1);
  localparam logic [LEFT_W-1:0] STEREO_MORE_READS = LEFT_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC    = 2'd0,
    CFG_SAMPLE_COUNT = 2'd1,
    CFG_STEREO       = 2'd2,
    CFG_LOOP_ENABLE  = 2'd3
  } cfg_idx_t;

  // What the word coming out of the memory means.
  typedef enum logic [1:0] {
    TK_A    = 2'd0,  // first word of a pair
    TK_B    = 2'd1,  // second word of a pair, interpolate now
    TK_ZERO = 2'd2   // silent tick, no word read
  } tok_kind_t;

  typedef struct packed {
    logic              valid;
    tok_kind_t         kind;
    logic              final_rd;
    logic              stereo;
    logic [FRAC_W-1:0] frac;
  } rd_tag_t;

  typedef struct packed {
    logic valid;
    logic final_rd;
    logic stereo;
  } val_tag_t;

endpackage

/* hw/rtl/interpolating_sample_player.sv */
// Interpolating sample player: sample memory, read position, read sequencer,
// interpolation pipeline and output word queue. Depends on isp_pkg.
//
// The block plays a 64K x 16 sample memory at a fractional rate set by a Q8.16 phase
// increment. Load words write the memory, note-on restarts playback at position zero,
// note-off silences it, and every tick word returns one output word: the linear
// interpolation between the current and the next sample (the average of both channels
// for interleaved stereo data). All sample reads go through one single-port memory with
// registered read data, so that port sets the rate: a mono tick reads two words and a
// stereo tick four, while a load writes one word and note-on, note-off and silent
// ticks read none. The next input word is taken as soon as the port is free. Results
// wait in a four-word queue; apart from a busy port, input is held off only while four
// tick results are outstanding. The memory has no reset and no clearing pass, so
// samples must be loaded before they are played. Configuration is to be written by the
// user through the cfg_ port while the block is idle; the block does not enforce this.
module interpolating_sample_player (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [isp_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [isp_pkg::OP_W-1:0]             in_op,
  input  logic [isp_pkg::ADDR_W-1:0]           in_load_address,
  input  logic signed [isp_pkg::SAMPLE_W-1:0]  in_load_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [isp_pkg::SAMPLE_W-1:0]  out_sample_out
);

  // Configuration registers.
  logic [isp_pkg::INC_W-1:0]   inc_r;
  logic [isp_pkg::COUNT_W-1:0] count_r;
  logic                        stereo_r;
  logic                        loop_r;

  // Playback state.
  logic [isp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      active_r, active_nxt;
  logic                      finished_r, finished_nxt;

  // Read sequencer: addresses still to read for the current tick.
  logic [isp_pkg::LEFT_W-1:0] rd_left_r, rd_left_nxt;
  logic                       rd_b_r, rd_b_nxt;
  logic [isp_pkg::ADDR_W-1:0] q1_r, q1_nxt, q2_r, q2_nxt, q3_r, q3_nxt;
  logic                       job_stereo_r, job_stereo_nxt;
  logic [isp_pkg::FRAC_W-1:0] job_frac_r, job_frac_nxt;

  // Memory port.
  logic [isp_pkg::SAMPLE_W-1:0] sample_mem [2**isp_pkg::ADDR_W];
  logic                         mem_we;
  logic [isp_pkg::ADDR_W-1:0]   mem_addr;
  logic [isp_pkg::SAMPLE_W-1:0] mem_wdata;
  logic [isp_pkg::SAMPLE_W-1:0] mem_q_r;

  isp_pkg::rd_tag_t  tag_nxt, tag1_r;
  isp_pkg::val_tag_t tag2_r;

  logic signed [isp_pkg::SAMPLE_W-1:0] a_r;
  logic signed [isp_pkg::VAL_W-1:0]    v_r, vl_r, v_calc;
  logic signed [isp_pkg::SAMPLE_W:0]   diff;
  logic signed [2*isp_pkg::SAMPLE_W+1:0] prod;
  logic signed [isp_pkg::VAL_W:0]      sum, sum_rnd;
  logic signed [isp_pkg::VAL_W-1:0]    v_rnd;
  logic [isp_pkg::SAMPLE_W-1:0]        res;
  logic                                push;

  // Output queue.
  logic [isp_pkg::SAMPLE_W-1:0] fifo_mem [isp_pkg::FIFO_DEPTH];
  logic [isp_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [isp_pkg::PEND_W-1:0]   fcnt_r, pend_r;

  logic in_accept, out_accept, tick_accept, silent;

  // Position decode for the tick at the input.
  logic [isp_pkg::COUNT_W-1:0] idx;
  logic [isp_pkg::FRAC_W-1:0]  frac;
  logic [isp_pkg::COUNT_W:0]   idx_p1, l_idx;
  logic [isp_pkg::COUNT_W+1:0] lp2, lp3;
  logic                        mono_wrap, nl_wrap, nr_wrap;
  logic [isp_pkg::ADDR_W-1:0]  addr0, addr1, addr2, addr3;
  logic [isp_pkg::POS_W-1:0]   pos_sum;
  logic signed [isp_pkg::COUNT_W+1:0] thr;
  logic [isp_pkg::POS_W:0]     pos_scaled;
  logic [isp_pkg::POS_W-1:0]   thr_sh;
  logic                        end_pass;

  assign in_ready   = (rd_left_r == '0) && (pend_r != isp_pkg::PEND_W'(isp_pkg::FIFO_DEPTH));
  assign in_accept  = in_valid && in_ready;
  assign out_valid  = (fcnt_r != '0);
  assign out_accept = out_valid && out_ready;
  assign tick_accept = in_accept && (isp_pkg::op_t'(in_op) == isp_pkg::OP_TICK);
  assign silent     = !active_r || finished_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r    <= isp_pkg::INC_RESET;
      count_r  <= isp_pkg::COUNT_RESET;
      stereo_r <= 1'b0;
      loop_r   <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (isp_pkg::cfg_idx_t'(cfg_index))
        isp_pkg::CFG_PHASE_INC:    inc_r    <= cfg_data[isp_pkg::INC_W-1:0];
        isp_pkg::CFG_SAMPLE_COUNT: count_r  <= cfg_data[isp_pkg::COUNT_W-1:0];
        isp_pkg::CFG_STEREO:       stereo_r <= cfg_data[0];
        isp_pkg::CFG_LOOP_ENABLE:  loop_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The integer part indexes mono words or stereo pairs. A next index at or past the
  // sample count wraps to the first word of its channel.
  always_comb begin
    idx       = pos_r[isp_pkg::POS_W-1:isp_pkg::FRAC_W];
    frac      = pos_r[isp_pkg::FRAC_W-1:0];
    idx_p1    = {1'b0, idx} + (isp_pkg::COUNT_W+1)'(1);
    l_idx     = {idx, 1'b0};
    lp2       = {1'b0, l_idx} + (isp_pkg::COUNT_W+2)'(2);
    lp3       = {1'b0, l_idx} + (isp_pkg::COUNT_W+2)'(3);
    mono_wrap = idx_p1 >= {1'b0, count_r};
    nl_wrap   = lp2 >= {2'b00, count_r};
    nr_wrap   = lp3 >= {2'b00, count_r};

    addr0 = stereo_r ? l_idx[isp_pkg::ADDR_W-1:0] : idx[isp_pkg::ADDR_W-1:0];
    if (stereo_r) begin
      addr1 = nl_wrap ? '0 : lp2[isp_pkg::ADDR_W-1:0];
    end else begin
      addr1 = mono_wrap ? '0 : idx_p1[isp_pkg::ADDR_W-1:0];
    end
    addr2 = l_idx[isp_pkg::ADDR_W-1:0] + isp_pkg::ADDR_W'(1);
    addr3 = nr_wrap ? isp_pkg::ADDR_W'(1) : lp3[isp_pkg::ADDR_W-1:0];

    // The pass ends when pos * channels exceeds (count - channels - 1) * 2^FRAC_W;
    // a negative threshold ends it on every tick.
    pos_sum    = pos_r + isp_pkg::POS_W'(inc_r);
    thr        = $signed({2'b00, count_r}) -
                 (stereo_r ? (isp_pkg::COUNT_W+2)'(3) : (isp_pkg::COUNT_W+2)'(2));
    thr_sh     = {thr[isp_pkg::COUNT_W-1:0], {isp_pkg::FRAC_W{1'b0}}};
    pos_scaled = stereo_r ? {pos_sum, 1'b0} : {1'b0, pos_sum};
    end_pass   = thr[isp_pkg::COUNT_W+1] || (pos_scaled > {1'b0, thr_sh});
  end

  // Port arbitration: outstanding tick reads own the port; otherwise the accepted word
  // uses it (a load writes, a playing tick issues its first read).
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = q1_r;
    mem_wdata      = in_load_data;
    tag_nxt        = '0;
    rd_left_nxt    = rd_left_r;
    rd_b_nxt       = rd_b_r;
    q1_nxt         = q1_r;
    q2_nxt         = q2_r;
    q3_nxt         = q3_r;
    job_stereo_nxt = job_stereo_r;
    job_frac_nxt   = job_frac_r;
    pos_nxt        = pos_r;
    active_nxt     = active_r;
    finished_nxt   = finished_r;
    if (rd_left_r != '0) begin
      tag_nxt.valid    = 1'b1;
      tag_nxt.kind     = rd_b_r ? isp_pkg::TK_B : isp_pkg::TK_A;
      tag_nxt.final_rd = (rd_left_r == isp_pkg::LEFT_W'(1));
      tag_nxt.stereo   = job_stereo_r;
      tag_nxt.frac     = job_frac_r;
      rd_left_nxt      = rd_left_r - isp_pkg::LEFT_W'(1);
      rd_b_nxt         = !rd_b_r;
      q1_nxt           = q2_r;
      q2_nxt           = q3_r;
    end else if (in_accept) begin
      unique case (isp_pkg::op_t'(in_op))
        isp_pkg::OP_LOAD: begin
          mem_we   = 1'b1;
          mem_addr = in_load_address;
        end
        isp_pkg::OP_NOTE_ON: begin
          pos_nxt      = '0;
          finished_nxt = 1'b0;
          active_nxt   = 1'b1;
        end
        isp_pkg::OP_NOTE_OFF: begin
          active_nxt = 1'b0;
        end
        isp_pkg::OP_TICK: begin
          if (silent) begin
            tag_nxt.valid    = 1'b1;
            tag_nxt.kind     = isp_pkg::TK_ZERO;
            tag_nxt.final_rd = 1'b1;
          end else begin
            mem_addr         = addr0;
            tag_nxt.valid    = 1'b1;
            tag_nxt.kind     = isp_pkg::TK_A;
            tag_nxt.stereo   = stereo_r;
            tag_nxt.frac     = frac;
            rd_left_nxt      = stereo_r ? isp_pkg::STEREO_MORE_READS
                                        : isp_pkg::MONO_MORE_READS;
            rd_b_nxt         = 1'b1;
            q1_nxt           = addr1;
            q2_nxt           = addr2;
            q3_nxt           = addr3;
            job_stereo_nxt   = stereo_r;
            job_frac_nxt     = frac;
            pos_nxt          = end_pass ? '0 : pos_sum;
            if (end_pass && !loop_r) begin
              finished_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      active_r   <= 1'b0;
      finished_r <= 1'b0;
      rd_left_r  <= '0;
      rd_b_r     <= 1'b0;
      tag1_r     <= '0;
    end else begin
      pos_r      <= pos_nxt;
      active_r   <= active_nxt;
      finished_r <= finished_nxt;
      rd_left_r  <= rd_left_nxt;
      rd_b_r     <= rd_b_nxt;
      tag1_r     <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q1_r         <= q1_nxt;
    q2_r         <= q2_nxt;
    q3_r         <= q3_nxt;
    job_stereo_r <= job_stereo_nxt;
    job_frac_r   <= job_frac_nxt;
  end

  // Single-port sample memory, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[mem_addr] <= mem_wdata;
    end
    mem_q_r <= sample_mem[mem_addr];
  end

  // Channel value v = a * 2^FRAC_W + (b - a) * frac, exact.
  always_comb begin
    diff   = $signed({mem_q_r[isp_pkg::SAMPLE_W-1], mem_q_r})
             - $signed({a_r[isp_pkg::SAMPLE_W-1], a_r});
    prod   = diff * $signed({1'b0, tag1_r.frac});
    v_calc = $signed({{(isp_pkg::VAL_W-isp_pkg::SAMPLE_W-isp_pkg::FRAC_W){a_r[isp_pkg::SAMPLE_W-1]}},
                      a_r, {isp_pkg::FRAC_W{1'b0}}})
             + isp_pkg::VAL_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (tag1_r.valid && (tag1_r.kind == isp_pkg::TK_A)) begin
      a_r <= $signed(mem_q_r);
    end
    if (tag1_r.valid && (tag1_r.kind == isp_pkg::TK_ZERO)) begin
      v_r <= '0;
    end else begin
      v_r <= v_calc;
    end
    // The left channel of a stereo tick waits here for the right one.
    if (tag2_r.valid && !tag2_r.final_rd) begin
      vl_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r.valid    <= tag1_r.valid && (tag1_r.kind != isp_pkg::TK_A);
      tag2_r.final_rd <= tag1_r.final_rd;
      tag2_r.stereo   <= tag1_r.stereo && (tag1_r.kind == isp_pkg::TK_B);
    end
  end

  // Round to nearest with halves up: mono divides by 2^FRAC_W, stereo sums both
  // channels and divides by 2^(FRAC_W+1).
  always_comb begin
    sum     = $signed({vl_r[isp_pkg::VAL_W-1], vl_r}) + $signed({v_r[isp_pkg::VAL_W-1], v_r});
    sum_rnd = sum + (isp_pkg::VAL_W+1)'(2**isp_pkg::FRAC_W);
    v_rnd   = v_r + isp_pkg::VAL_W'(2**(isp_pkg::FRAC_W-1));
    res     = tag2_r.stereo ? sum_rnd[isp_pkg::FRAC_W+1 +: isp_pkg::SAMPLE_W]
                            : v_rnd[isp_pkg::FRAC_W +: isp_pkg::SAMPLE_W];
    push    = tag2_r.valid && tag2_r.final_rd;
  end

  // Output queue. pend_r counts tick results not yet taken, in flight or queued, so a
  // push never finds the queue full.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      pend_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + isp_pkg::FIFO_AW'(1);
      end
      if (out_accept) begin
        rd_ptr_r <= rd_ptr_r + isp_pkg::FIFO_AW'(1);
      end
      fcnt_r <= fcnt_r + isp_pkg::PEND_W'(push) - isp_pkg::PEND_W'(out_accept);
      pend_r <= pend_r + isp_pkg::PEND_W'(tick_accept) - isp_pkg::PEND_W'(out_accept);
    end
  end

  assign out_sample_out = $signed(fifo_mem[rd_ptr_r]);

endmodule

/* verif/interpolating_sample_player_tb.sv */
// Self-checking testbench for interpolating_sample_player: directed playback cases, then
// random sessions of loads, notes and ticks checked against an in-bench player model.
// Depends on isp_pkg and the interpolating_sample_player RTL only.
module interpolating_sample_player_tb;
  import isp_pkg::*;

  // Length of the long output stall and the quiet time allowed after the last result.
  localparam int HOLD_CYCLES        = 300;
  localparam int SETTLE_CYCLES      = 8;
  localparam int WORDS_PER_SCHEDULE = 220;
  localparam logic [SAMPLE_W-1:0] MOST_NEGATIVE = 16'h8000;
  localparam logic [SAMPLE_W-1:0] MOST_POSITIVE = 16'h7FFF;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_write_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [OP_W-1:0]             in_op;
  logic [ADDR_W-1:0]           in_load_address;
  logic signed [SAMPLE_W-1:0]  in_load_data;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [SAMPLE_W-1:0]  out_sample_out;

  interpolating_sample_player u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_load_address (in_load_address),
    .in_load_data    (in_load_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Player model. The sample memory keeps a written flag per word so that a tick is
  // never sent while it would read a word that has not been loaded yet.
  logic signed [SAMPLE_W-1:0] sample_mem [0:(1<<ADDR_W)-1];
  bit                         sample_written [0:(1<<ADDR_W)-1];
  logic [POS_W-1:0]           play_pos;
  bit                         playing;
  bit                         play_done;
  logic [INC_W-1:0]           cur_inc;
  logic [COUNT_W-1:0]         cur_count;
  bit                         cur_stereo;
  bit                         cur_loop;

  // Output words still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] pending_samples [$];

  int errors;
  int words_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_seq;

  // Addresses one tick reads: current and next word, then the right channel pair in
  // stereo. A next index past the last stored word wraps to the first word of its
  // channel, also when a register change has left the position beyond the data.
  function automatic void tick_reads(output longint a0, output longint a1,
                                     output longint a2, output longint a3);
    longint idx;
    longint cnt;
    idx = longint'(play_pos >> FRAC_W);
    cnt = longint'(cur_count);
    if (!cur_stereo) begin
      a0 = idx;
      a1 = (idx + 1 > cnt - 1) ? 0 : idx + 1;
      a2 = a0;
      a3 = a1;
    end else begin
      a0 = idx * 2;
      a1 = (a0 + 2 > cnt - 1) ? 0 : a0 + 2;
      a2 = a0 + 1;
      a3 = (a2 + 2 > cnt - 1) ? 1 : a2 + 2;
    end
  endfunction

  // One channel scaled by 2^16: a*2^16 + (b-a)*frac, exact.
  function automatic longint weighted(longint ia, longint ib, longint frac);
    longint a;
    longint b;
    a = sample_mem[ia[ADDR_W-1:0]];
    b = sample_mem[ib[ADDR_W-1:0]];
    return a * (longint'(1) << FRAC_W) + (b - a) * frac;
  endfunction

  // Produces the word one tick owes and moves the read position on.
  function automatic void advance_player();
    longint a0, a1, a2, a3;
    longint frac;
    longint v;
    longint ch;
    longint thr;
    if (!playing || play_done) begin
      pending_samples.push_back('0);
      return;
    end
    frac = longint'(play_pos[FRAC_W-1:0]);
    tick_reads(a0, a1, a2, a3);
    // Arithmetic shift after adding half a step rounds to nearest, halves upward.
    if (!cur_stereo)
      v = (weighted(a0, a1, frac) + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    else
      v = (weighted(a0, a1, frac) + weighted(a2, a3, frac) + (longint'(1) << FRAC_W))
          >>> (FRAC_W + 1);
    pending_samples.push_back(v[SAMPLE_W-1:0]);
    play_pos = play_pos + POS_W'(cur_inc);
    // Past the end threshold (count-ch-1)/ch the pass is over; with a tiny count the
    // threshold is negative and every tick ends the pass.
    ch  = cur_stereo ? 2 : 1;
    thr = (longint'(cur_count) - ch - 1) * (longint'(1) << FRAC_W);
    if (longint'(play_pos) * ch > thr) begin
      play_pos = '0;
      if (!cur_loop)
        play_done = 1'b1;
    end
  endfunction

  function automatic void apply_word(op_t op, logic [ADDR_W-1:0] addr,
                                     logic [SAMPLE_W-1:0] data);
    case (op)
      OP_LOAD: begin
        sample_mem[addr]     = data;
        sample_written[addr] = 1'b1;
      end
      OP_NOTE_ON: begin
        play_pos  = '0;
        play_done = 1'b0;
        playing   = 1'b1;
      end
      OP_NOTE_OFF: playing = 1'b0;
      default: advance_player();
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return MOST_NEGATIVE;
    if (r < 10)
      return MOST_POSITIVE;
    return SAMPLE_W'($urandom);
  endfunction

  // Offers one word on the input channel and waits for it to be taken. Valid is only
  // lowered when a random gap is inserted, so back-to-back words keep it high.
  task automatic send_word(op_t op, logic [ADDR_W-1:0] addr, logic [SAMPLE_W-1:0] data);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        in_valid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_load_address <= addr;
    in_load_data    <= data;
    do @(posedge clk); while (!in_ready);
    apply_word(op, addr, data);
    words_sent++;
  endtask

  // Before a tick that plays, any word it would read that was never loaded gets loaded
  // with random content first.
  task automatic send_tick();
    longint rd [4];
    if (playing && !play_done) begin
      tick_reads(rd[0], rd[1], rd[2], rd[3]);
      foreach (rd[k])
        if (!sample_written[rd[k][ADDR_W-1:0]])
          send_word(OP_LOAD, rd[k][ADDR_W-1:0], random_sample());
    end
    send_word(OP_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic load_block(int n);
    for (int i = 0; i < n; i++)
      send_word(OP_LOAD, ADDR_W'(i), random_sample());
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++)
      send_tick();
  endtask

  // Stops offering words until every owed word has arrived, then lets the pipeline
  // drain the words that give no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    case (idx)
      CFG_PHASE_INC:    cur_inc    = value[INC_W-1:0];
      CFG_SAMPLE_COUNT: cur_count  = value[COUNT_W-1:0];
      CFG_STEREO:       cur_stereo = value[0];
      default:          cur_loop   = value[0];
    endcase
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [INC_W-1:0] inc, logic [COUNT_W-1:0] count,
                           bit stereo_on, bit loop_on);
    wait_idle();
    write_register(CFG_PHASE_INC, CFG_W'(inc));
    write_register(CFG_SAMPLE_COUNT, CFG_W'(count));
    write_register(CFG_STEREO, CFG_W'(stereo_on));
    write_register(CFG_LOOP_ENABLE, CFG_W'(loop_on));
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // With the reset settings: a tick before any note is silent, whole steps give the
  // stored words at both extremes, and note-off silences the output again.
  task automatic test_reset_settings();
    send_tick();
    send_word(OP_LOAD, 16'd0, MOST_POSITIVE);
    send_word(OP_LOAD, 16'd1, MOST_NEGATIVE);
    send_word(OP_LOAD, 16'd2, 16'd0);
    send_word(OP_LOAD, 16'hFFFF, 16'h1234);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    send_ticks(3);
    send_word(OP_NOTE_OFF, 16'd0, 16'd0);
    send_tick();
  endtask

  // Half steps land exactly between words, so the rounding of halves is exercised,
  // including the full-scale pair whose midpoint is minus one half.
  task automatic test_half_step_rounding();
    configure(24'h008000, 17'd65536, 1'b0, 1'b0);
    send_word(OP_LOAD, 16'd3, 16'hFFFF);
    send_word(OP_LOAD, 16'd4, 16'hFFFE);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    send_ticks(9);
  endtask

  // Five interleaved words: the right channel's next index wraps to word one on the
  // second frame, and the third tick finds the one-shot pass finished.
  task automatic test_stereo_pairs();
    configure(24'h010000, 17'd5, 1'b1, 1'b0);
    load_block(5);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    send_ticks(3);
  endtask

  // The largest increment passes the end on every tick; loop mode restarts at zero.
  task automatic test_loop_restart();
    configure(24'hFFFFFF, 17'd4, 1'b0, 1'b1);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    send_ticks(3);
  endtask

  // Counts below the usual minimum: zero to two give a negative end threshold, three in stereo a zero one.
  task automatic test_tiny_counts();
    for (int c = 0; c < 4; c++) begin
      configure(24'h000000, COUNT_W'(c), c >= 2, 1'b0);
      send_word(OP_NOTE_ON, 16'd0, 16'd0);
      send_ticks(2);
    end
  endtask

  // Play far into a long buffer, then shrink the count so that the next index of the
  // stale position wraps to the first word.
  task automatic test_stale_position();
    configure(24'hFFFFFF, 17'd65536, 1'b0, 1'b0);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    send_ticks(3);
    wait_idle();
    write_register(CFG_SAMPLE_COUNT, CFG_W'(4));
    send_ticks(2);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the result
  // queue fills up and the input stalls.
  task automatic test_output_hold();
    configure(24'h00C000, 17'd16, 1'b0, 1'b1);
    send_word(OP_NOTE_ON, 16'd0, 16'd0);
    set_idling(0, 0);
    hold_seq <= hold_seq + 1;
    send_ticks(24);
    wait_idle();
    set_idling(7, 61);
  endtask

  // One random session: idle pause, new settings, then a burst of mostly ticks with
  // some loads and note changes in between.
  task automatic random_session();
    int r;
    int n;
    logic [COUNT_W-1:0] count;
    logic [INC_W-1:0] inc;
    r = $urandom_range(99);
    if (r < 6)
      count = COUNT_W'($urandom_range(3));
    else if (r < 12)
      count = 17'd65536;
    else if (r < 15)
      count = 17'h1FFFF;
    else
      count = COUNT_W'($urandom_range(4, 48));
    r = $urandom_range(99);
    if (r < 10)
      inc = '0;
    else if (r < 20)
      inc = '1;
    else if (r < 35)
      inc = 24'h010000;
    else if (r < 70)
      inc = INC_W'($urandom_range(1, 24'h030000));
    else
      inc = INC_W'($urandom);
    configure(inc, count, 1'($urandom_range(1)), 1'($urandom_range(1)));
    if (count <= 48 && $urandom_range(1))
      load_block(int'(count));
    if ($urandom_range(9) != 0)
      send_word(OP_NOTE_ON, ADDR_W'($urandom), SAMPLE_W'($urandom));
    n = $urandom_range(10, 40);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 72)
        send_tick();
      else if (r < 80)
        send_word(OP_LOAD, ADDR_W'($urandom), random_sample());
      else if (r < 88)
        send_word(OP_NOTE_ON, ADDR_W'($urandom), SAMPLE_W'($urandom));
      else if (r < 94)
        send_word(OP_NOTE_OFF, ADDR_W'($urandom), SAMPLE_W'($urandom));
      else
        send_word(OP_LOAD, ADDR_W'($urandom_range(47)), random_sample());
    end
  endtask

  task automatic test_random_playback();
    int start;
    for (int s = 0; s < 3; s++) begin
      if (s == 0)
        set_idling(7, 61);
      else if (s == 1)
        set_idling(61, 7);
      else
        set_idling(0, 0);
      start = words_sent;
      while (words_sent - start < WORDS_PER_SCHEDULE)
        random_session();
    end
  endtask

  // Result side: checks every accepted word against the oldest owed one and drives
  // ready, with random stalls and the long hold requested through hold_seq.
  initial begin
    int stall_left;
    int hold_seen;
    logic signed [SAMPLE_W-1:0] want;
    stall_left = 0;
    hold_seen  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: sample_out expected none actual %0d", $time, out_sample_out);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (out_sample_out !== want) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, want, out_sample_out);
            errors++;
          end
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5000000;
    $display("interpolating_sample_player_tb: errors");
    $finish;
  end

  initial begin
    errors        = 0;
    words_sent    = 0;
    hold_seq      = 0;
    play_pos      = '0;
    playing       = 1'b0;
    play_done     = 1'b0;
    cur_inc       = INC_RESET;
    cur_count     = COUNT_RESET;
    cur_stereo    = 1'b0;
    cur_loop      = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 61;
    rst_n           <= 1'b0;
    cfg_write_en    <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_op           <= '0;
    in_load_address <= '0;
    in_load_data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_half_step_rounding();
    test_stereo_pairs();
    test_loop_restart();
    test_tiny_counts();
    test_stale_position();
    test_output_hold();
    test_random_playback();

    wait_idle();
    if (errors == 0)
      $display("interpolating_sample_player_tb: clean");
    else
      $display("interpolating_sample_player_tb: errors");
    $finish;
  end

endmodule
